/* rtl/core/x86mov_pkg.sv */
// x86mov_pkg: shared codes and opcode patterns for the 8086 mov byte decoder
// no dependencies; used by the decoder top level and its checker
`default_nettype none

package x86mov_pkg;

    // record kinds
    typedef enum logic [2:0] {
        KIND_REGMEM = 3'd0,
        KIND_IMMRM  = 3'd1,
        KIND_IMMREG = 3'd2,
        KIND_MEMACC = 3'd3,
        KIND_ACCMEM = 3'd4,
        KIND_BAD    = 3'd5
    } op_kind_t;

    // first-byte opcode patterns
    localparam logic [5:0] OPC_REGMEM = 6'b100010;
    localparam logic [3:0] OPC_IMMREG = 4'b1011;
    localparam logic [6:0] OPC_IMMRM  = 7'b1100011;
    localparam logic [6:0] OPC_MEMACC = 7'b1010000;
    localparam logic [6:0] OPC_ACCMEM = 7'b1010001;

    // mod and r/m codes with special meaning
    localparam logic [1:0] MOD_MEM    = 2'd0;
    localparam logic [1:0] MOD_DISP8  = 2'd1;
    localparam logic [1:0] MOD_DISP16 = 2'd2;
    localparam logic [1:0] MOD_REG    = 2'd3;
    localparam logic [2:0] RM_DIRECT  = 3'd6;

    localparam int unsigned MAX_LENGTH = 6;

endpackage

`default_nettype wire

/* rtl/core/x86_16_mov_byte_decoder.sv */
// x86_16_mov_byte_decoder: decodes the five 8086 mov forms from a byte stream
// depends on x86mov_pkg
//
//  channel | signals                                   | role
//  in      | in_valid, in_ready, code_byte             | one code byte per word
//  out     | out_valid, out_ready, op_kind .. length   | one decoded record per word
//
// one byte is taken per cycle while in_ready is high; a record appears in the cycle after its last byte
// the record sits in an output register, and in_ready stays high while it is
// being taken, so a stream of bytes flows without gaps
// out_ready low with a record waiting holds in_ready low
// reset clears the partial instruction and drops any waiting record
`default_nettype none

module x86_16_mov_byte_decoder (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [7:0]  code_byte,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [2:0]       op_kind,
    output logic             wide,
    output logic             to_reg,
    output logic [1:0]       mode_bits,
    output logic [2:0]       reg_code,
    output logic [2:0]       rm_code,
    output logic             direct_address,
    output logic [15:0]      displacement,
    output logic [15:0]      immediate,
    output logic [2:0]       length
);
    import x86mov_pkg::*;

    // partial instruction state
    logic [2:0] byte_index_reg, byte_index_next;
    op_kind_t   kind_held_reg, kind_held_next;
    logic       wide_held_reg, wide_held_next;
    logic       dir_held_reg, dir_held_next;
    logic [1:0] mode_held_reg, mode_held_next;
    logic [2:0] reg_held_reg, reg_held_next;
    logic [2:0] rm_held_reg, rm_held_next;
    logic [7:0] disp_low_reg, disp_low_next;
    logic [7:0] disp_high_reg, disp_high_next;
    logic [7:0] data_low_reg, data_low_next;

    // output record registers
    logic        out_valid_reg;
    logic [2:0]  op_kind_reg, op_kind_next;
    logic        wide_reg, wide_next;
    logic        to_reg_reg, to_reg_next;
    logic [1:0]  mode_bits_reg, mode_bits_next;
    logic [2:0]  reg_code_reg, reg_code_next;
    logic [2:0]  rm_code_reg, rm_code_next;
    logic        direct_reg, direct_next;
    logic [15:0] disp_reg, disp_next;
    logic [15:0] imm_reg, imm_next;
    logic [2:0]  length_reg, length_next;

    logic       accept;
    logic       done;
    logic       modrm_kind;
    logic [2:0] hdr;
    logic [2:0] nd_held;
    logic [2:0] nd_new;
    logic [2:0] nd_data;
    logic [2:0] t_off;
    logic [2:0] len;
    logic [7:0] data_high;

    // displacement byte count for a kind and mod/rm
    function automatic logic [2:0] disp_count(op_kind_t k, logic [1:0] m, logic [2:0] r);
        logic [2:0] n;
        n = 3'd0;
        if (k == KIND_MEMACC || k == KIND_ACCMEM)
        begin
            n = 3'd2;
        end
        else if (k == KIND_REGMEM || k == KIND_IMMRM)
        begin
            if (m == MOD_DISP8)
                n = 3'd1;
            else if (m == MOD_DISP16)
                n = 3'd2;
            else if (m == MOD_MEM && r == RM_DIRECT)
                n = 3'd2;
        end
        return n;
    endfunction

    assign accept   = in_valid && in_ready;
    assign in_ready = !out_valid_reg || out_ready;

    // byte decode and next state
    always_comb
    begin
        byte_index_next = byte_index_reg;
        kind_held_next  = kind_held_reg;
        wide_held_next  = wide_held_reg;
        dir_held_next   = dir_held_reg;
        mode_held_next  = mode_held_reg;
        reg_held_next   = reg_held_reg;
        rm_held_next    = rm_held_reg;
        disp_low_next   = disp_low_reg;
        disp_high_next  = disp_high_reg;
        data_low_next   = data_low_reg;
        data_high       = 8'd0;
        done            = 1'b0;
        modrm_kind      = (kind_held_reg == KIND_REGMEM) || (kind_held_reg == KIND_IMMRM);
        hdr             = modrm_kind ? 3'd2 : 3'd1;
        nd_held         = disp_count(kind_held_reg, mode_held_reg, rm_held_reg);
        t_off           = byte_index_reg - hdr;
        nd_new          = 3'd0;
        nd_data         = 3'd0;
        len             = 3'd1;

        op_kind_next   = KIND_BAD;
        wide_next      = 1'b0;
        to_reg_next    = 1'b0;
        mode_bits_next = 2'd0;
        reg_code_next  = 3'd0;
        rm_code_next   = 3'd0;
        direct_next    = 1'b0;
        disp_next      = 16'd0;
        imm_next       = 16'd0;
        length_next    = 3'd1;

        if (byte_index_reg == 3'd0)
        begin
            // opcode byte
            byte_index_next = 3'd1;
            if (code_byte[7:2] == OPC_REGMEM)
            begin
                kind_held_next = KIND_REGMEM;
                dir_held_next  = code_byte[1];
                wide_held_next = code_byte[0];
            end
            else if (code_byte[7:1] == OPC_IMMRM)
            begin
                kind_held_next = KIND_IMMRM;
                wide_held_next = code_byte[0];
            end
            else if (code_byte[7:4] == OPC_IMMREG)
            begin
                kind_held_next = KIND_IMMREG;
                wide_held_next = code_byte[3];
                reg_held_next  = code_byte[2:0];
            end
            else if (code_byte[7:1] == OPC_MEMACC)
            begin
                kind_held_next = KIND_MEMACC;
                wide_held_next = code_byte[0];
            end
            else if (code_byte[7:1] == OPC_ACCMEM)
            begin
                kind_held_next = KIND_ACCMEM;
                wide_held_next = code_byte[0];
            end
            else
            begin
                byte_index_next = 3'd0;
                done            = 1'b1;
            end
        end
        else
        begin
            // mod-r/m, displacement or data byte
            if (modrm_kind && byte_index_reg == 3'd1)
            begin
                mode_held_next = code_byte[7:6];
                reg_held_next  = code_byte[5:3];
                rm_held_next   = code_byte[2:0];
            end
            else if (byte_index_reg >= hdr)
            begin
                if (t_off < nd_held)
                begin
                    if (t_off == 3'd0)
                        disp_low_next = code_byte;
                    else
                        disp_high_next = code_byte;
                end
                else if (t_off == nd_held)
                begin
                    data_low_next = code_byte;
                end
                else
                begin
                    data_high = code_byte;
                end
            end

            nd_new = disp_count(kind_held_reg, mode_held_next, rm_held_next);
            if (kind_held_reg == KIND_IMMRM || kind_held_reg == KIND_IMMREG)
                nd_data = {2'b00, wide_held_reg} + 3'd1;
            len = hdr + nd_new + nd_data;

            if ({1'b0, byte_index_reg} + 4'd1 < {1'b0, len})
            begin
                byte_index_next = byte_index_reg + 3'd1;
            end
            else
            begin
                done            = 1'b1;
                byte_index_next = 3'd0;
                op_kind_next    = kind_held_reg;
                wide_next       = wide_held_reg;
                length_next     = len;
                if (nd_new == 3'd1)
                    disp_next = {{8{disp_low_next[7]}}, disp_low_next};
                else if (nd_new == 3'd2)
                    disp_next = {disp_high_next, disp_low_next};
                if (nd_data != 3'd0)
                    imm_next = {data_high, data_low_next};
                case (kind_held_reg)
                    KIND_REGMEM, KIND_IMMRM:
                    begin
                        to_reg_next    = (kind_held_reg == KIND_REGMEM) ? dir_held_reg : 1'b0;
                        mode_bits_next = mode_held_next;
                        reg_code_next  = reg_held_next;
                        rm_code_next   = rm_held_next;
                        direct_next    = (mode_held_next == MOD_MEM)
                                         && (rm_held_next == RM_DIRECT);
                    end
                    KIND_IMMREG:
                    begin
                        to_reg_next    = 1'b1;
                        mode_bits_next = MOD_REG;
                        reg_code_next  = reg_held_reg;
                    end
                    default:
                    begin
                        to_reg_next  = (kind_held_reg == KIND_MEMACC);
                        rm_code_next = RM_DIRECT;
                        direct_next  = 1'b1;
                    end
                endcase
            end
        end

        // a finished instruction leaves a clean state
        if (done)
        begin
            kind_held_next = KIND_REGMEM;
            wide_held_next = 1'b0;
            dir_held_next  = 1'b0;
            mode_held_next = 2'd0;
            reg_held_next  = 3'd0;
            rm_held_next   = 3'd0;
            disp_low_next  = 8'd0;
            disp_high_next = 8'd0;
            data_low_next  = 8'd0;
        end
    end

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_index_reg <= 3'd0;
            kind_held_reg  <= KIND_REGMEM;
            wide_held_reg  <= 1'b0;
            dir_held_reg   <= 1'b0;
            mode_held_reg  <= 2'd0;
            reg_held_reg   <= 3'd0;
            rm_held_reg    <= 3'd0;
            disp_low_reg   <= 8'd0;
            disp_high_reg  <= 8'd0;
            data_low_reg   <= 8'd0;
        end
        else if (accept)
        begin
            byte_index_reg <= byte_index_next;
            kind_held_reg  <= kind_held_next;
            wide_held_reg  <= wide_held_next;
            dir_held_reg   <= dir_held_next;
            mode_held_reg  <= mode_held_next;
            reg_held_reg   <= reg_held_next;
            rm_held_reg    <= rm_held_next;
            disp_low_reg   <= disp_low_next;
            disp_high_reg  <= disp_high_next;
            data_low_reg   <= data_low_next;
        end
    end

    // output word valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (accept && done)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    // output record payload
    always_ff @(posedge clk)
    begin
        if (accept && done)
        begin
            op_kind_reg   <= op_kind_next;
            wide_reg      <= wide_next;
            to_reg_reg    <= to_reg_next;
            mode_bits_reg <= mode_bits_next;
            reg_code_reg  <= reg_code_next;
            rm_code_reg   <= rm_code_next;
            direct_reg    <= direct_next;
            disp_reg      <= disp_next;
            imm_reg       <= imm_next;
            length_reg    <= length_next;
        end
    end

    assign out_valid      = out_valid_reg;
    assign op_kind        = op_kind_reg;
    assign wide           = wide_reg;
    assign to_reg         = to_reg_reg;
    assign mode_bits      = mode_bits_reg;
    assign reg_code       = reg_code_reg;
    assign rm_code        = rm_code_reg;
    assign direct_address = direct_reg;
    assign displacement   = disp_reg;
    assign immediate      = imm_reg;
    assign length         = length_reg;

endmodule

`default_nettype wire

/* rtl/core/x86mov_checker.sv */
// x86mov_checker: port-level checks on decoded records, bound to the top level
// depends on x86mov_pkg and x86_16_mov_byte_decoder
`default_nettype none

module x86mov_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        out_valid,
    input wire logic        out_ready,
    input wire logic [2:0]  op_kind,
    input wire logic        wide,
    input wire logic        to_reg,
    input wire logic [1:0]  mode_bits,
    input wire logic [2:0]  reg_code,
    input wire logic [2:0]  rm_code,
    input wire logic        direct_address,
    input wire logic [15:0] displacement,
    input wire logic [15:0] immediate,
    input wire logic [2:0]  length
);
    import x86mov_pkg::*;

    // a stalled word holds its record
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(op_kind) && $stable(length)
            && $stable(displacement) && $stable(immediate))
        else $error("stalled output word changed");

    // unknown opcode gives a bare one-byte record
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && op_kind == KIND_BAD |-> length == 3'd1 && displacement == 16'd0
            && immediate == 16'd0 && !wide && !direct_address)
        else $error("bad opcode record carries data");

    // length stays within one to six bytes
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> length != 3'd0 && length <= 3'(MAX_LENGTH))
        else $error("record length out of range");

    // immediate to register form
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && op_kind == KIND_IMMREG |-> mode_bits == MOD_REG && to_reg
            && !direct_address && length == 3'd2 + {2'b00, wide})
        else $error("imm-reg record malformed");

    // accumulator forms always carry a direct 16-bit address
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (op_kind == KIND_MEMACC || op_kind == KIND_ACCMEM)
            |-> length == 3'd3 && rm_code == RM_DIRECT && direct_address
            && reg_code == 3'd0 && immediate == 16'd0)
        else $error("accumulator record malformed");

endmodule

bind x86_16_mov_byte_decoder x86mov_checker u_x86mov_checker (.*);

`default_nettype wire
